// ===== hdl/slts_pkg.sv =====
// shared types, constants and byte classification for the token scanner
// used by every module of the scanner; depends on nothing
package slts_pkg;

    // position counter width and the fixed result field widths
    localparam int OFFSET_BITS = 16;
    localparam int OUT_OFFSET_BITS = 16;
    localparam int LEN_BITS = 16;
    localparam logic [LEN_BITS-1:0] LEN_MAX = {LEN_BITS{1'b1}};

    // queue between front and back, in result pairs
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS = $clog2(QUEUE_DEPTH + 1);

    // scan modes
    localparam logic [2:0] MODE_START    = 3'd0;
    localparam logic [2:0] MODE_ATOM     = 3'd1;
    localparam logic [2:0] MODE_COMMENT  = 3'd2;
    localparam logic [2:0] MODE_NUMBER   = 3'd3;
    localparam logic [2:0] MODE_OPERATOR = 3'd4;
    localparam logic [2:0] MODE_STRING   = 3'd5;
    localparam logic [2:0] MODE_VARIABLE = 3'd6;

    // token kinds
    localparam logic [3:0] KIND_ATOM      = 4'd0;
    localparam logic [3:0] KIND_COMMENT   = 4'd1;
    localparam logic [3:0] KIND_NUMBER    = 4'd2;
    localparam logic [3:0] KIND_OPERATOR  = 4'd3;
    localparam logic [3:0] KIND_STRING    = 4'd4;
    localparam logic [3:0] KIND_VARIABLE  = 4'd5;
    localparam logic [3:0] KIND_PAREN     = 4'd6;
    localparam logic [3:0] KIND_SEMICOLON = 4'd7;
    localparam logic [3:0] KIND_ERROR     = 4'd8;

    // byte classes seen from the start state
    localparam logic [3:0] CL_ATOM     = 4'd0;
    localparam logic [3:0] CL_VARIABLE = 4'd1;
    localparam logic [3:0] CL_COMMENT  = 4'd2;
    localparam logic [3:0] CL_OPERATOR = 4'd3;
    localparam logic [3:0] CL_STRING   = 4'd4;
    localparam logic [3:0] CL_NUMBER   = 4'd5;
    localparam logic [3:0] CL_SEMI     = 4'd6;
    localparam logic [3:0] CL_PAREN    = 4'd7;
    localparam logic [3:0] CL_SPACE    = 4'd8;
    localparam logic [3:0] CL_ERROR    = 4'd9;

    typedef struct packed {
        logic [3:0]                 kind;
        logic [OUT_OFFSET_BITS-1:0] offset;
        logic [LEN_BITS-1:0]        length;
    } result_t;

    // results caused by one byte; second is valid only when two is set
    typedef struct packed {
        result_t first;
        result_t second;
        logic    two;
    } pair_t;

    function automatic logic is_lower(input logic [7:0] b);
        return (b >= "a") && (b <= "z");
    endfunction

    function automatic logic is_upper(input logic [7:0] b);
        return (b >= "A") && (b <= "Z");
    endfunction

    function automatic logic is_decimal(input logic [7:0] b);
        return (b >= "0") && (b <= "9");
    endfunction

    function automatic logic is_word(input logic [7:0] b);
        return is_lower(b) || is_upper(b) || is_decimal(b) || (b == "_");
    endfunction

    function automatic logic is_op(input logic [7:0] b);
        logic r;
        unique case (b)
            "+", "-", "/", "*", "=", ":", "?", "!", "@",
            "$", "%", "\\", "|", "^", "&", ">", "<", ",": r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic is_space(input logic [7:0] b);
        return (b == " ") || (b == "\n") || (b == "\r") || (b == "\t");
    endfunction

    // class of a byte when no token is pending, first match wins
    function automatic logic [3:0] classify(input logic [7:0] b);
        logic [3:0] c;
        priority if (is_lower(b))                   c = CL_ATOM;
        else if (is_upper(b) || (b == "_"))         c = CL_VARIABLE;
        else if (b == "#")                          c = CL_COMMENT;
        else if (is_op(b))                          c = CL_OPERATOR;
        else if (b == "\"")                         c = CL_STRING;
        else if (is_decimal(b))                     c = CL_NUMBER;
        else if (b == ";")                          c = CL_SEMI;
        else if ((b == "(") || (b == ")") || (b == "{") || (b == "}"))
                                                    c = CL_PAREN;
        else if (is_space(b))                       c = CL_SPACE;
        else                                        c = CL_ERROR;
        return c;
    endfunction

    function automatic logic [3:0] mode_to_kind(input logic [2:0] m);
        logic [3:0] k;
        unique case (m)
            MODE_ATOM:     k = KIND_ATOM;
            MODE_COMMENT:  k = KIND_COMMENT;
            MODE_NUMBER:   k = KIND_NUMBER;
            MODE_OPERATOR: k = KIND_OPERATOR;
            MODE_STRING:   k = KIND_STRING;
            MODE_VARIABLE: k = KIND_VARIABLE;
            default:       k = KIND_ERROR;
        endcase
        return k;
    endfunction

    // low bits of the position counter as reported offset
    function automatic logic [OUT_OFFSET_BITS-1:0] to_offset(
        input logic [OFFSET_BITS-1:0] pos
    );
        logic [31:0] wide;
        wide = 32'(pos);
        return wide[OUT_OFFSET_BITS-1:0];
    endfunction

endpackage

// ===== hdl/slts_front.sv =====
// front end: accepts source beats, runs the scanner state and builds result pairs
// depends on slts_pkg
module slts_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           src_valid,
    output logic           src_stall,
    input  logic [7:0]     source_byte,
    input  logic           end_of_stream,
    output logic           push,
    output slts_pkg::pair_t push_data,
    input  logic           full
);
    import slts_pkg::*;

    logic [2:0]             mode_reg, mode_next;
    logic [OFFSET_BITS-1:0] pos_reg, pos_next;
    logic [OFFSET_BITS-1:0] begin_reg, begin_next;
    logic [LEN_BITS-1:0]    cnt_reg, cnt_next;
    logic                   err_reg, err_next;

    logic                   accept;
    logic [3:0]             start_class;
    logic [OFFSET_BITS-1:0] pos_inc;
    logic [LEN_BITS-1:0]    cnt_inc;
    logic                   more;
    logic                   push_any;
    result_t                close_res;

    // start-state pass
    logic                   sp_emit;
    result_t                sp_res;
    logic [2:0]             sp_mode;
    logic [OFFSET_BITS-1:0] sp_begin;
    logic [LEN_BITS-1:0]    sp_cnt;
    logic [OFFSET_BITS-1:0] sp_pos;
    logic                   sp_err;

    assign src_stall = full;
    assign accept    = src_valid && !full;
    assign push      = accept && push_any;

    // what the byte would do with no token pending
    always_comb
    begin
        start_class = classify(source_byte);
        pos_inc     = pos_reg + OFFSET_BITS'(1);
        sp_emit     = 1'b0;
        sp_res      = '{kind: KIND_ERROR, offset: to_offset(pos_reg), length: LEN_BITS'(1)};
        sp_mode     = MODE_START;
        sp_begin    = begin_reg;
        sp_cnt      = cnt_reg;
        sp_pos      = pos_inc;
        sp_err      = 1'b0;
        unique case (start_class)
            CL_ATOM:
            begin
                sp_mode  = MODE_ATOM;
                sp_begin = pos_reg;
                sp_cnt   = LEN_BITS'(1);
            end
            CL_VARIABLE:
            begin
                sp_mode  = MODE_VARIABLE;
                sp_begin = pos_reg;
                sp_cnt   = LEN_BITS'(1);
            end
            CL_COMMENT:
            begin
                sp_mode  = MODE_COMMENT;
                sp_begin = pos_reg;
                sp_cnt   = LEN_BITS'(1);
            end
            CL_OPERATOR:
            begin
                sp_mode  = MODE_OPERATOR;
                sp_begin = pos_reg;
                sp_cnt   = LEN_BITS'(1);
            end
            CL_STRING:
            begin
                sp_mode  = MODE_STRING;
                sp_begin = pos_reg;
                sp_cnt   = LEN_BITS'(1);
            end
            CL_NUMBER:
            begin
                sp_mode  = MODE_NUMBER;
                sp_begin = pos_reg;
                sp_cnt   = LEN_BITS'(1);
            end
            CL_SEMI:
            begin
                sp_emit     = 1'b1;
                sp_res.kind = KIND_SEMICOLON;
            end
            CL_PAREN:
            begin
                sp_emit     = 1'b1;
                sp_res.kind = KIND_PAREN;
            end
            CL_SPACE:
            begin
                sp_mode = MODE_START;
            end
            // unexpected byte: error beat, position held, flag set
            default:
            begin
                sp_emit = 1'b1;
                sp_pos  = pos_reg;
                sp_err  = 1'b1;
            end
        endcase
    end

    // does the pending token go on with this byte
    always_comb
    begin
        unique case (mode_reg)
            MODE_ATOM, MODE_VARIABLE: more = is_word(source_byte);
            MODE_NUMBER:              more = is_decimal(source_byte);
            MODE_OPERATOR:            more = is_op(source_byte);
            MODE_COMMENT:             more = (source_byte != "\n");
            default:                  more = 1'b0;
        endcase
    end

    // scanner step
    always_comb
    begin
        cnt_inc    = (cnt_reg == LEN_MAX) ? cnt_reg : cnt_reg + LEN_BITS'(1);
        close_res  = '{kind: mode_to_kind(mode_reg), offset: to_offset(begin_reg),
                       length: cnt_reg};
        mode_next  = mode_reg;
        pos_next   = pos_reg;
        begin_next = begin_reg;
        cnt_next   = cnt_reg;
        err_next   = err_reg;
        push_any   = 1'b0;
        push_data  = '{first: sp_res, second: sp_res, two: 1'b0};
        priority if (end_of_stream)
        begin
            // flush pending token, then back to reset values
            if ((mode_reg != MODE_START) && !err_reg)
            begin
                push_any        = 1'b1;
                push_data.first = close_res;
            end
            mode_next  = MODE_START;
            pos_next   = '0;
            begin_next = '0;
            cnt_next   = '0;
            err_next   = 1'b0;
        end
        else if (err_reg)
        begin
            push_any = 1'b0;
        end
        else if (mode_reg == MODE_START)
        begin
            push_any   = sp_emit;
            mode_next  = sp_mode;
            pos_next   = sp_pos;
            begin_next = sp_begin;
            cnt_next   = sp_cnt;
            err_next   = sp_err;
        end
        else if (mode_reg == MODE_STRING)
        begin
            // closing quote is part of the string
            cnt_next = cnt_inc;
            pos_next = pos_inc;
            if (source_byte == "\"")
            begin
                push_any        = 1'b1;
                push_data.first = '{kind: KIND_STRING, offset: to_offset(begin_reg),
                                    length: cnt_inc};
                mode_next       = MODE_START;
            end
        end
        else if (more)
        begin
            cnt_next = cnt_inc;
            pos_next = pos_inc;
        end
        else
        begin
            // close the token and look at the byte again from start
            push_any         = 1'b1;
            push_data.first  = close_res;
            push_data.second = sp_res;
            push_data.two    = sp_emit;
            mode_next        = sp_mode;
            pos_next         = sp_pos;
            begin_next       = sp_begin;
            cnt_next         = sp_cnt;
            err_next         = sp_err;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_START;
            pos_reg   <= '0;
            begin_reg <= '0;
            cnt_reg   <= '0;
            err_reg   <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg  <= mode_next;
            pos_reg   <= pos_next;
            begin_reg <= begin_next;
            cnt_reg   <= cnt_next;
            err_reg   <= err_next;
        end
    end

endmodule

// ===== hdl/slts_queue.sv =====
// short queue of result pairs between the front and back ends
// depends on slts_pkg
module slts_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  slts_pkg::pair_t push_data,
    output logic            full,
    input  logic            pop,
    output slts_pkg::pair_t head,
    output logic            empty
);
    import slts_pkg::*;

    localparam logic [QPTR_BITS-1:0] PTR_LAST = QPTR_BITS'(QUEUE_DEPTH - 1);

    pair_t                slot_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_BITS-1:0] cnt_reg, cnt_next;
    logic                 do_push, do_pop;

    assign full    = (cnt_reg == QCNT_BITS'(QUEUE_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = slot_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + QPTR_BITS'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + QPTR_BITS'(1);
        end
        unique case ({do_push, do_pop})
            2'b10:   cnt_next = cnt_reg + QCNT_BITS'(1);
            2'b01:   cnt_next = cnt_reg - QCNT_BITS'(1);
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // slot storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== hdl/slts_back.sv =====
// back end: unpacks result pairs into single token beats behind an output register
// depends on slts_pkg
module slts_back (
    input  logic            clk,
    input  logic            rst_n,
    input  slts_pkg::pair_t head,
    input  logic            empty,
    output logic            pop,
    output logic            tok_valid,
    input  logic            tok_stall,
    output logic [3:0]      token_kind,
    output logic [15:0]     token_offset,
    output logic [15:0]     token_length,
    output logic            run_last
);
    import slts_pkg::*;

    logic       half_reg, half_next;
    logic       valid_reg, valid_next;
    result_t    res_reg;
    logic       last_reg;
    logic       load;
    logic       is_last;
    result_t    pick;

    assign load    = !empty && (!valid_reg || !tok_stall);
    assign is_last = !head.two || half_reg;
    assign pick    = half_reg ? head.second : head.first;
    assign pop     = load && is_last;

    // output valid and position inside the head pair
    always_comb
    begin
        half_next  = half_reg;
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
            half_next  = !is_last;
        end
        else if (!tok_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            half_reg  <= half_next;
            valid_reg <= valid_next;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg  <= pick;
            last_reg <= is_last;
        end
    end

    assign tok_valid    = valid_reg;
    assign token_kind   = res_reg.kind;
    assign token_offset = res_reg.offset;
    assign token_length = res_reg.length;
    assign run_last     = last_reg;

endmodule

// ===== hdl/source_lexer_token_scanner_unit.sv =====
// token scanner top level: front end, result queue and back end
// depends on slts_pkg, slts_front, slts_queue, slts_back
//
// usage
//   source channel (src_valid / src_stall): one beat per source byte, or an
//   end_of_stream beat that flushes the pending token and returns the scanner
//   to its reset state. a byte is taken at every clock edge with src_valid
//   high and src_stall low, so bytes stream in at one per cycle.
//   token channel (tok_valid / tok_stall): one beat per token, with kind,
//   start offset, length and run_last marking the last beat a source beat gave.
//   a source beat gives zero, one or two token beats.
// order and flow
//   the first token beat of a source beat is written into the result queue and
//   then into the output register. the token side moves one beat per cycle
//   while tok_stall is low; a source beat that gives two tokens needs two
//   output beats, and a queue of four result pairs between front and back
//   absorbs that. src_stall rises only while that queue is full.
// reset and stall
//   rst_n clears scanner state, position and sticky error, and empties the
//   queue. while tok_stall is high the output beat holds and the queue fills.
module source_lexer_token_scanner_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        src_valid,
    output logic        src_stall,
    input  logic [7:0]  source_byte,
    input  logic        end_of_stream,
    output logic        tok_valid,
    input  logic        tok_stall,
    output logic [3:0]  token_kind,
    output logic [15:0] token_offset,
    output logic [15:0] token_length,
    output logic        run_last
);
    import slts_pkg::*;

    logic  push;
    pair_t push_data;
    logic  full;
    logic  pop;
    pair_t head;
    logic  empty;

    slts_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .src_valid     (src_valid),
        .src_stall     (src_stall),
        .source_byte   (source_byte),
        .end_of_stream (end_of_stream),
        .push          (push),
        .push_data     (push_data),
        .full          (full)
    );

    slts_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .head      (head),
        .empty     (empty)
    );

    slts_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .empty        (empty),
        .pop          (pop),
        .tok_valid    (tok_valid),
        .tok_stall    (tok_stall),
        .token_kind   (token_kind),
        .token_offset (token_offset),
        .token_length (token_length),
        .run_last     (run_last)
    );

endmodule
